@@ hdl/heartbeat_watchdog_supervisor_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Heartbeat watchdog supervisor assertion macros
// Shared property wrappers, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef HEARTBEAT_WATCHDOG_SUPERVISOR_UNIT_ASSERT_SVH
`define HEARTBEAT_WATCHDOG_SUPERVISOR_UNIT_ASSERT_SVH

// Same-cycle implication
`define HWS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hws assertion failed");

// Next-cycle implication
`define HWS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hws assertion failed");

`endif

@@ hdl/hws_pkg.sv @@
// ----------------------------------------------------------------------------
// hws_pkg
// Widths, command codes, reply words and the base table of the supervisor.
// ----------------------------------------------------------------------------
package hws_pkg;

  // Field widths
  localparam int CODE_W    = 7;
  localparam int RESP_W    = 16;
  localparam int BASE_W    = 7;
  localparam int MULT_W    = 5;
  localparam int FAULT_W   = 8;
  localparam int LIMIT_W   = BASE_W + MULT_W;

  // Default width of the seconds counter
  localparam int ELAPSED_BITS_DEF = 16;

  // Action codes
  localparam logic ACT_TICK    = 1'b0;
  localparam logic ACT_COMMAND = 1'b1;

  // Command codes
  localparam logic [CODE_W-1:0] CMD_PING        = 7'd0;
  localparam logic [CODE_W-1:0] CMD_UNLOCK      = 7'd1;
  localparam logic [CODE_W-1:0] CMD_LOCK        = 7'd2;
  localparam logic [CODE_W-1:0] CMD_VERSION     = 7'd3;
  localparam logic [CODE_W-1:0] CMD_DATE        = 7'd4;
  localparam logic [CODE_W-1:0] CMD_REBOOT_PRI  = 7'd6;
  localparam logic [CODE_W-1:0] CMD_CLEAR_CNT   = 7'd7;
  localparam logic [CODE_W-1:0] CMD_PRI_FAULTS  = 7'd8;
  localparam logic [CODE_W-1:0] CMD_SELF_FAULTS = 7'd9;
  localparam logic [CODE_W-1:0] CMD_TGT_MAIN    = 7'd11;
  localparam logic [CODE_W-1:0] CMD_TGT_SAVING  = 7'd12;
  localparam logic [CODE_W-1:0] CMD_REBOOT_SELF = 7'd13;
  localparam logic [CODE_W-1:0] CMD_ENABLE      = 7'd30;
  localparam logic [CODE_W-1:0] CMD_DISABLE     = 7'd31;
  localparam logic [CODE_W-1:0] CMD_HEARTBEAT   = 7'd32;
  localparam logic [CODE_W-1:0] CMD_BASE_LO     = 7'd40;
  localparam logic [CODE_W-1:0] CMD_BASE_HI     = 7'd49;
  localparam logic [CODE_W-1:0] CMD_MULT_LO     = 7'd50;
  localparam logic [CODE_W-1:0] CMD_MULT_HI     = 7'd69;
  // Multiplier value is the code minus this offset
  localparam logic [CODE_W-1:0] MULT_OFFSET     = 7'd49;

  // Reply words
  localparam logic [RESP_W-1:0] REPLY_OK      = 16'd0;
  localparam logic [RESP_W-1:0] REPLY_ERROR   = 16'd1;
  localparam logic [RESP_W-1:0] REPLY_INVALID = 16'd2;
  localparam logic [RESP_W-1:0] REPLY_PING    = 16'd3;
  localparam logic [RESP_W-1:0] REPLY_LOCKED  = 16'd4;
  localparam logic [RESP_W-1:0] VERSION_WORD  = 16'd180;
  localparam logic [RESP_W-1:0] DATE_WORD     = 16'd336;

  // Interval target
  localparam logic TGT_MAIN   = 1'b0;
  localparam logic TGT_SAVING = 1'b1;

  // Reset values of the interval settings
  localparam logic [BASE_W-1:0] BASE_RST = 7'd15;
  localparam logic [MULT_W-1:0] MULT_RST = 5'd8;

  // Number of valid base table entries
  localparam logic [CODE_W-1:0] BASE_ENTRIES = 7'd7;

  // Base table, seconds
  function automatic logic [BASE_W-1:0] base_lookup(input logic [2:0] idx);
    logic [BASE_W-1:0] val;
    case (idx)
      3'd0:    val = 7'd1;
      3'd1:    val = 7'd5;
      3'd2:    val = 7'd10;
      3'd3:    val = 7'd15;
      3'd4:    val = 7'd30;
      3'd5:    val = 7'd60;
      3'd6:    val = 7'd90;
      default: val = 7'd0;
    endcase
    return val;
  endfunction

endpackage

@@ hdl/hws_if.sv @@
// ----------------------------------------------------------------------------
// hws request and result channels
// Valid/ready channels carrying one request item and one result item.
// ----------------------------------------------------------------------------

// Request channel: tick or command byte
interface hws_in_if;
  import hws_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [CODE_W-1:0] command_code;

  modport source (output valid, output action, output command_code, input ready);
  modport sink   (input valid, input action, input command_code, output ready);
endinterface

// Result channel: reply word and reboot pulses
interface hws_out_if;
  import hws_pkg::*;

  logic              valid;
  logic              ready;
  logic [RESP_W-1:0] response;
  logic              has_response;
  logic              reboot_primary;
  logic              reboot_self;

  modport source (output valid, output response, output has_response,
                  output reboot_primary, output reboot_self, input ready);
  modport sink   (input valid, input response, input has_response,
                  input reboot_primary, input reboot_self, output ready);
endinterface

@@ hdl/heartbeat_watchdog_supervisor_unit.sv @@
// ----------------------------------------------------------------------------
// Heartbeat watchdog supervisor
// Counts one-second ticks, times out the supervised processor while
// monitoring, and answers configuration and status commands.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake     Carries
//  request   in   valid/ready   action, command_code
//  result    out  valid/ready   response, has_response, reboot_primary,
//                               reboot_self
//
//  One request per cycle while ready is high; its result (if any) is registered
//  in the output register, or waits in the skid while that register is stalled.
//  Each request is decoded and applied in the accept cycle; the output
//  register plus one skid entry decouple the two sides.
//  ready drops only while both output entries are full (result stalled).
//  Synchronous reset returns all watchdog state to its reset values; no clearing pass is needed.
//
`include "heartbeat_watchdog_supervisor_unit_assert.svh"

module heartbeat_watchdog_supervisor_unit #(
  parameter int ELAPSED_BITS = hws_pkg::ELAPSED_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  hws_in_if.sink     request,
  hws_out_if.source  result
);
  import hws_pkg::*;

  typedef struct packed {
    logic [RESP_W-1:0] response;
    logic              has_response;
    logic              reboot_primary;
    logic              reboot_self;
  } result_t;

  localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = {ELAPSED_BITS{1'b1}};

  // Watchdog state
  logic                    monitor_enabled,   monitor_enabled_next;
  logic                    config_unlocked,   config_unlocked_next;
  logic                    interval_target,   interval_target_next;
  logic [ELAPSED_BITS-1:0] elapsed_seconds,   elapsed_seconds_next;
  logic [BASE_W-1:0]       main_base,         main_base_next;
  logic [MULT_W-1:0]       main_multiplier,   main_multiplier_next;
  logic [BASE_W-1:0]       saving_base,       saving_base_next;
  logic [MULT_W-1:0]       saving_multiplier, saving_multiplier_next;
  logic [FAULT_W-1:0]      primary_faults,    primary_faults_next;

  // Output register and skid entry
  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;

  logic                    in_fire;
  logic                    slot_free;
  logic                    produce;
  logic                    timeout;
  result_t                 new_res;
  logic [LIMIT_W-1:0]      limit;
  logic [ELAPSED_BITS-1:0] elapsed_sat;
  logic [CODE_W-1:0]       base_sel;
  logic [CODE_W-1:0]       mult_val;
  logic [BASE_W-1:0]       base_val;

  assign request.ready = !skid_valid;
  assign in_fire       = request.valid && request.ready;
  assign slot_free     = !out_valid || result.ready;

  // Timeout limit and saturating tick count
  assign limit       = LIMIT_W'(main_base) * LIMIT_W'(main_multiplier);
  assign elapsed_sat = (elapsed_seconds == ELAPSED_MAX) ? elapsed_seconds
                                                        : elapsed_seconds + 1'b1;
  assign timeout     = monitor_enabled && (elapsed_sat > ELAPSED_BITS'(limit));

  // Base and multiplier decode
  assign base_sel = request.command_code - CMD_BASE_LO;
  assign mult_val = request.command_code - MULT_OFFSET;
  assign base_val = base_lookup(base_sel[2:0]);

  // Request decode and state update
  always_comb begin
    monitor_enabled_next   = monitor_enabled;
    config_unlocked_next   = config_unlocked;
    interval_target_next   = interval_target;
    elapsed_seconds_next   = elapsed_seconds;
    main_base_next         = main_base;
    main_multiplier_next   = main_multiplier;
    saving_base_next       = saving_base;
    saving_multiplier_next = saving_multiplier;
    primary_faults_next    = primary_faults;
    produce                = 1'b0;
    new_res                = '0;

    if (in_fire) begin
      if (request.action == ACT_TICK) begin
        elapsed_seconds_next = elapsed_sat;
        if (timeout) begin
          monitor_enabled_next   = 1'b0;
          config_unlocked_next   = 1'b0;
          elapsed_seconds_next   = '0;
          primary_faults_next    = primary_faults + 1'b1;
          produce                = 1'b1;
          new_res.reboot_primary = 1'b1;
          new_res.reboot_self    = 1'b1;
        end
      end else begin
        // every command returns one result, possibly empty
        produce = 1'b1;
        case (request.command_code)
          CMD_PING: begin
            new_res.response     = REPLY_PING;
            new_res.has_response = 1'b1;
          end
          CMD_UNLOCK: begin
            config_unlocked_next = 1'b1;
            new_res.has_response = 1'b1;
          end
          CMD_LOCK: begin
            config_unlocked_next = 1'b0;
            new_res.has_response = 1'b1;
          end
          CMD_VERSION: begin
            new_res.response     = VERSION_WORD;
            new_res.has_response = 1'b1;
          end
          CMD_DATE: begin
            new_res.response     = DATE_WORD;
            new_res.has_response = 1'b1;
          end
          CMD_REBOOT_PRI: begin
            new_res.reboot_primary = 1'b1;
          end
          CMD_CLEAR_CNT: begin
            primary_faults_next  = '0;
            new_res.has_response = 1'b1;
          end
          CMD_PRI_FAULTS: begin
            new_res.response     = RESP_W'(primary_faults);
            new_res.has_response = 1'b1;
          end
          CMD_SELF_FAULTS: begin
            // nothing counts supervisor faults
            new_res.has_response = 1'b1;
          end
          CMD_REBOOT_SELF: begin
            new_res.reboot_self = 1'b1;
          end
          CMD_ENABLE, CMD_DISABLE, CMD_HEARTBEAT: begin
            new_res.has_response = 1'b1;
            if ((request.command_code == CMD_ENABLE) ? !monitor_enabled
                                                     : monitor_enabled) begin
              if (request.command_code == CMD_ENABLE) begin
                monitor_enabled_next = 1'b1;
              end
              if (request.command_code == CMD_DISABLE) begin
                monitor_enabled_next = 1'b0;
              end
              elapsed_seconds_next = '0;
              config_unlocked_next = 1'b0;
            end else begin
              new_res.response = REPLY_INVALID;
            end
          end
          CMD_TGT_MAIN, CMD_TGT_SAVING: begin
            if (!config_unlocked) begin
              new_res.response     = REPLY_LOCKED;
              new_res.has_response = 1'b1;
            end else begin
              interval_target_next = (request.command_code == CMD_TGT_SAVING)
                                     ? TGT_SAVING : TGT_MAIN;
            end
          end
          default: begin
            if (request.command_code >= CMD_BASE_LO &&
                request.command_code <= CMD_BASE_HI) begin
              new_res.has_response = 1'b1;
              if (!config_unlocked) begin
                new_res.response = REPLY_LOCKED;
              end else if (base_sel < BASE_ENTRIES) begin
                if (interval_target == TGT_MAIN) begin
                  main_base_next = base_val;
                end else begin
                  saving_base_next = base_val;
                end
                new_res.response = RESP_W'(base_val);
              end else begin
                new_res.response = REPLY_ERROR;
              end
            end else if (request.command_code >= CMD_MULT_LO &&
                         request.command_code <= CMD_MULT_HI) begin
              new_res.has_response = 1'b1;
              if (!config_unlocked) begin
                new_res.response = REPLY_LOCKED;
              end else begin
                if (interval_target == TGT_MAIN) begin
                  main_multiplier_next = mult_val[MULT_W-1:0];
                end else begin
                  saving_multiplier_next = mult_val[MULT_W-1:0];
                end
                new_res.response = RESP_W'(mult_val[MULT_W-1:0]);
              end
            end
            // unused codes: empty result
          end
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      monitor_enabled   <= 1'b0;
      config_unlocked   <= 1'b0;
      interval_target   <= TGT_MAIN;
      elapsed_seconds   <= '0;
      main_base         <= BASE_RST;
      main_multiplier   <= MULT_RST;
      saving_base       <= BASE_RST;
      saving_multiplier <= MULT_RST;
      primary_faults    <= '0;
    end else begin
      monitor_enabled   <= monitor_enabled_next;
      config_unlocked   <= config_unlocked_next;
      interval_target   <= interval_target_next;
      elapsed_seconds   <= elapsed_seconds_next;
      main_base         <= main_base_next;
      main_multiplier   <= main_multiplier_next;
      saving_base       <= saving_base_next;
      saving_multiplier <= saving_multiplier_next;
      primary_faults    <= primary_faults_next;
    end
  end

  // Output register and skid control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (slot_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= produce;
      end
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (slot_free) begin
      out_data <= skid_valid ? skid_data : new_res;
    end else if (produce) begin
      skid_data <= new_res;
    end
  end

  assign result.valid          = out_valid;
  assign result.response       = out_data.response;
  assign result.has_response   = out_data.has_response;
  assign result.reboot_primary = out_data.reboot_primary;
  assign result.reboot_self    = out_data.reboot_self;

  // Assertions
  `HWS_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid)
  `HWS_ASSERT_NOW(a_reply_no_reboot, result.valid && result.has_response,
    !result.reboot_primary && !result.reboot_self)
  `HWS_ASSERT_NOW(a_empty_reply_zero, result.valid && !result.has_response,
    result.response == REPLY_OK)
  `HWS_ASSERT_NEXT(a_timeout_disarms, in_fire && request.action == ACT_TICK && timeout,
    !monitor_enabled && !config_unlocked && elapsed_seconds == '0)
  // enabling from the disabled state arms the watchdog and locks the settings
  `HWS_ASSERT_NEXT(a_enable_locks,
    in_fire && request.action == ACT_COMMAND && request.command_code == CMD_ENABLE
      && !monitor_enabled,
    monitor_enabled && !config_unlocked)

endmodule

@@ bench/tb_heartbeat_watchdog_supervisor_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_heartbeat_watchdog_supervisor_unit
// Self-checking bench for the heartbeat watchdog supervisor. A directed table
// of requests comes first: replies after reset, locked settings, range limits
// and a first timeout. It is followed by a timeout at the largest base, a run
// of back-to-back short timeouts, and random mixes of tuning, watch, feed,
// status and noise requests under four idling patterns.
// Every accepted request is run through a local model of the supervisor, and
// each result is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module tb_heartbeat_watchdog_supervisor_unit;
  import hws_pkg::*;

  localparam int SECS_W       = ELAPSED_BITS_DEF;
  localparam int LIMIT_CYCLES = 400000;

  // Codes the block does not decode
  localparam logic [CODE_W-1:0] CMD_SPARE     = 7'd5;
  localparam logic [CODE_W-1:0] CMD_SPARE_MAX = 7'd127;

  // Base table in seconds, entry 0 in the low bits
  localparam logic [7*BASE_W-1:0] BASE_SECS =
    {7'd90, 7'd60, 7'd30, 7'd15, 7'd10, 7'd5, 7'd1};

  typedef struct packed {
    logic [RESP_W-1:0] response;
    logic              has_response;
    logic              reboot_primary;
    logic              reboot_self;
  } hws_result_t;

  typedef struct {
    logic              act;
    logic [CODE_W-1:0] code;
    bit                fixed;
    hws_result_t       want;
  } plan_row_t;

  logic clk;
  logic rst;

  hws_in_if  request_ch ();
  hws_out_if result_ch ();

  heartbeat_watchdog_supervisor_unit #(
    .ELAPSED_BITS (SECS_W)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .request (request_ch),
    .result  (result_ch)
  );

  // Model state of the supervisor
  logic              wd_on;
  logic              cfg_open;
  logic              tgt;
  logic [SECS_W-1:0] secs;
  logic [BASE_W-1:0] main_base;
  logic [MULT_W-1:0] main_mult;
  logic [BASE_W-1:0] save_base;
  logic [MULT_W-1:0] save_mult;
  logic [7:0]        fault_cnt;

  hws_result_t reply_q[$];
  plan_row_t   directed_rows[$];
  int          error_cnt;
  int          items_sent;
  int          send_idle_pct;
  int          recv_stall_pct;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("tb_heartbeat_watchdog_supervisor_unit: done, errors");
    $finish;
  end

  // Applies one request to the model; returns 1 when it yields a result
  function automatic bit next_reply(input logic act, input logic [CODE_W-1:0] code,
                                    output hws_result_t rsp);
    logic [LIMIT_W-1:0] lim;
    logic [CODE_W-1:0]  sel;
    logic [BASE_W-1:0]  bval;
    logic [MULT_W-1:0]  mval;
    rsp = '0;
    // tick: saturating count, timeout when past the main interval
    if (act == ACT_TICK) begin
      if (secs != '1) secs = secs + 1'b1;
      lim = LIMIT_W'(main_base) * LIMIT_W'(main_mult);
      if (wd_on && secs > SECS_W'(lim)) begin
        wd_on              = 1'b0;
        cfg_open           = 1'b0;
        secs               = '0;
        fault_cnt          = fault_cnt + 1'b1;
        rsp.reboot_primary = 1'b1;
        rsp.reboot_self    = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    end
    // command: always a result, mostly with a reply word
    rsp.has_response = 1'b1;
    if (code == CMD_PING) rsp.response = REPLY_PING;
    else if (code == CMD_UNLOCK) cfg_open = 1'b1;
    else if (code == CMD_LOCK) cfg_open = 1'b0;
    else if (code == CMD_VERSION) rsp.response = VERSION_WORD;
    else if (code == CMD_DATE) rsp.response = DATE_WORD;
    else if (code == CMD_REBOOT_PRI) begin
      rsp.has_response   = 1'b0;
      rsp.reboot_primary = 1'b1;
    end else if (code == CMD_CLEAR_CNT) fault_cnt = '0;
    else if (code == CMD_PRI_FAULTS) rsp.response = RESP_W'(fault_cnt);
    else if (code == CMD_SELF_FAULTS) rsp.response = REPLY_OK;  // never counted
    else if (code == CMD_REBOOT_SELF) begin
      rsp.has_response = 1'b0;
      rsp.reboot_self  = 1'b1;
    end else if (code == CMD_ENABLE || code == CMD_DISABLE || code == CMD_HEARTBEAT) begin
      // enable needs monitoring off; disable and heartbeat need it on
      if ((code == CMD_ENABLE) != wd_on) begin
        if (code == CMD_ENABLE) wd_on = 1'b1;
        else if (code == CMD_DISABLE) wd_on = 1'b0;
        secs     = '0;
        cfg_open = 1'b0;
      end else begin
        rsp.response = REPLY_INVALID;
      end
    end else if (code == CMD_TGT_MAIN || code == CMD_TGT_SAVING) begin
      if (!cfg_open) rsp.response = REPLY_LOCKED;
      else begin
        tgt              = (code == CMD_TGT_SAVING) ? TGT_SAVING : TGT_MAIN;
        rsp.has_response = 1'b0;
      end
    end else if (code >= CMD_BASE_LO && code <= CMD_BASE_HI) begin
      sel = code - CMD_BASE_LO;
      if (!cfg_open) rsp.response = REPLY_LOCKED;
      else if (sel < BASE_ENTRIES) begin
        bval = BASE_SECS[sel*BASE_W +: BASE_W];
        if (tgt == TGT_SAVING) save_base = bval;
        else main_base = bval;
        rsp.response = RESP_W'(bval);
      end else begin
        rsp.response = REPLY_ERROR;
      end
    end else if (code >= CMD_MULT_LO && code <= CMD_MULT_HI) begin
      mval = MULT_W'(code - MULT_OFFSET);
      if (!cfg_open) rsp.response = REPLY_LOCKED;
      else begin
        if (tgt == TGT_SAVING) save_mult = mval;
        else main_mult = mval;
        rsp.response = RESP_W'(mval);
      end
    end else begin
      rsp.has_response = 1'b0;
    end
    return 1'b1;
  endfunction

  // Directed table entry; fixed rows carry their expected result
  function automatic void add_row(input logic act, input logic [CODE_W-1:0] code,
                                  input int fixed, input logic [RESP_W-1:0] resp,
                                  input int has, input int rbp, input int rbs);
    plan_row_t r;
    r.act                 = act;
    r.code                = code;
    r.fixed               = (fixed != 0);
    r.want.response       = resp;
    r.want.has_response   = (has != 0);
    r.want.reboot_primary = (rbp != 0);
    r.want.reboot_self    = (rbs != 0);
    directed_rows.push_back(r);
  endfunction

  // Drives one request; entered and left at a falling edge
  task automatic issue_request(input logic act, input logic [CODE_W-1:0] code,
                               input bit fixed, input hws_result_t want);
    hws_result_t pred;
    bit          got;
    while ($urandom_range(99) < send_idle_pct) begin
      request_ch.valid <= 1'b0;
      @(negedge clk);
    end
    request_ch.valid        <= 1'b1;
    request_ch.action       <= act;
    request_ch.command_code <= code;
    @(posedge clk);
    while (request_ch.ready !== 1'b1) @(posedge clk);
    items_sent++;
    got = next_reply(act, code, pred);
    if (fixed) reply_q.push_back(want);
    else if (got) reply_q.push_back(pred);
    @(negedge clk);
  endtask

  task automatic send_tick();
    issue_request(ACT_TICK, CODE_W'($urandom_range(127)), 1'b0, '0);
  endtask

  task automatic send_cmd(input logic [CODE_W-1:0] code);
    issue_request(ACT_COMMAND, code, 1'b0, '0);
  endtask

  // Random mix of request sequences, stopping once the budget is spent
  task automatic run_mixed(input int budget);
    int stop_at;
    int pick;
    int n;
    int lim;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      lim  = int'(main_base) * int'(main_mult);
      if (pick < 25) begin
        // retune: mostly short intervals so timeouts come often
        if ($urandom_range(9) != 0) send_cmd(CMD_UNLOCK);
        send_cmd($urandom_range(3) == 0 ? CMD_TGT_SAVING : CMD_TGT_MAIN);
        send_cmd(CMD_BASE_LO + CODE_W'($urandom_range(4) != 0 ? $urandom_range(2)
                                                              : $urandom_range(9)));
        send_cmd(CMD_MULT_LO + CODE_W'($urandom_range(4) != 0 ? $urandom_range(3)
                                                              : $urandom_range(19)));
        if ($urandom_range(3) == 0) send_cmd(CMD_LOCK);
      end else if (pick < 55) begin
        // watch: enable and tick up to just past the interval
        send_cmd($urandom_range(4) == 0 ? CMD_HEARTBEAT : CMD_ENABLE);
        n = (lim > 40) ? $urandom_range(1, 20) : lim - 1 + $urandom_range(3);
        repeat (n) begin
          if ($urandom_range(49) == 0) send_cmd(CMD_HEARTBEAT);
          send_tick();
        end
      end else if (pick < 70) begin
        // feed: heartbeats keep the counter under the interval
        send_cmd(CMD_ENABLE);
        repeat ($urandom_range(1, 3)) begin
          repeat ($urandom_range(lim > 40 ? 20 : lim)) send_tick();
          send_cmd(CMD_HEARTBEAT);
        end
        send_cmd(CMD_DISABLE);
      end else if (pick < 88) begin
        // status and reboot requests
        case ($urandom_range(8))
          0: send_cmd(CMD_PING);
          1: send_cmd(CMD_VERSION);
          2: send_cmd(CMD_DATE);
          3: send_cmd(CMD_PRI_FAULTS);
          4: send_cmd(CMD_SELF_FAULTS);
          5: send_cmd(CMD_CLEAR_CNT);
          6: send_cmd(CMD_REBOOT_PRI);
          7: send_cmd(CMD_REBOOT_SELF);
          default: send_cmd(CMD_LOCK);
        endcase
      end else begin
        // noise: any code, or stray ticks
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(1) == 0) send_tick();
          else send_cmd(CODE_W'($urandom_range(127)));
        end
      end
    end
  endtask

  // Receiver: random stalls on the result channel
  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker
  always @(posedge clk) begin : check_results
    hws_result_t want;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (reply_q.size() == 0) begin
        $error("unexpected result: response %0d has_response %0b reboot %0b/%0b",
               result_ch.response, result_ch.has_response,
               result_ch.reboot_primary, result_ch.reboot_self);
        error_cnt++;
      end else begin
        want = reply_q.pop_front();
        if (result_ch.response !== want.response) begin
          $error("response: expected %0d, got %0d", want.response, result_ch.response);
          error_cnt++;
        end
        if (result_ch.has_response !== want.has_response) begin
          $error("has_response: expected %0b, got %0b",
                 want.has_response, result_ch.has_response);
          error_cnt++;
        end
        if (result_ch.reboot_primary !== want.reboot_primary) begin
          $error("reboot_primary: expected %0b, got %0b",
                 want.reboot_primary, result_ch.reboot_primary);
          error_cnt++;
        end
        if (result_ch.reboot_self !== want.reboot_self) begin
          $error("reboot_self: expected %0b, got %0b",
                 want.reboot_self, result_ch.reboot_self);
          error_cnt++;
        end
      end
    end
  end

  // Reset, stimulus and end of run
  initial begin
    int round;
    rst                     = 1'b1;
    request_ch.valid        = 1'b0;
    request_ch.action       = ACT_TICK;
    request_ch.command_code = '0;
    result_ch.ready         = 1'b0;
    error_cnt               = 0;
    items_sent              = 0;
    send_idle_pct           = 0;
    recv_stall_pct          = 0;
    wd_on                   = 1'b0;
    cfg_open                = 1'b0;
    tgt                     = TGT_MAIN;
    secs                    = '0;
    main_base               = BASE_RST;
    main_mult               = MULT_RST;
    save_base               = BASE_RST;
    save_mult               = MULT_RST;
    fault_cnt               = '0;

    // directed: locked state after reset, range edges, first timeout
    add_row(ACT_COMMAND, CMD_PING,        1, REPLY_PING,    1, 0, 0);
    add_row(ACT_COMMAND, CMD_VERSION,     1, VERSION_WORD,  1, 0, 0);
    add_row(ACT_COMMAND, CMD_DATE,        1, DATE_WORD,     1, 0, 0);
    add_row(ACT_COMMAND, CMD_SPARE,       1, REPLY_OK,      0, 0, 0);
    add_row(ACT_COMMAND, CMD_SPARE_MAX,   1, REPLY_OK,      0, 0, 0);
    add_row(ACT_COMMAND, CMD_PRI_FAULTS,  1, REPLY_OK,      1, 0, 0);
    add_row(ACT_COMMAND, CMD_SELF_FAULTS, 1, REPLY_OK,      1, 0, 0);
    add_row(ACT_COMMAND, CMD_BASE_LO,     1, REPLY_LOCKED,  1, 0, 0);
    add_row(ACT_COMMAND, CMD_MULT_HI,     1, REPLY_LOCKED,  1, 0, 0);
    add_row(ACT_COMMAND, CMD_TGT_SAVING,  1, REPLY_LOCKED,  1, 0, 0);
    add_row(ACT_COMMAND, CMD_DISABLE,     1, REPLY_INVALID, 1, 0, 0);
    add_row(ACT_COMMAND, CMD_HEARTBEAT,   1, REPLY_INVALID, 1, 0, 0);
    add_row(ACT_COMMAND, CMD_REBOOT_PRI,  1, REPLY_OK,      0, 1, 0);
    add_row(ACT_COMMAND, CMD_REBOOT_SELF, 1, REPLY_OK,      0, 0, 1);
    add_row(ACT_COMMAND, CMD_UNLOCK,      1, REPLY_OK,      1, 0, 0);
    add_row(ACT_COMMAND, CMD_TGT_SAVING,  0, '0, 0, 0, 0);
    add_row(ACT_COMMAND, CMD_MULT_HI,     0, '0, 0, 0, 0);
    add_row(ACT_COMMAND, CMD_TGT_MAIN,    0, '0, 0, 0, 0);
    add_row(ACT_COMMAND, CMD_BASE_LO + BASE_ENTRIES - 1, 0, '0, 0, 0, 0);
    add_row(ACT_COMMAND, CMD_BASE_LO + BASE_ENTRIES,     1, REPLY_ERROR, 1, 0, 0);
    add_row(ACT_COMMAND, CMD_BASE_LO,     1, 16'd1,         1, 0, 0);
    add_row(ACT_COMMAND, CMD_MULT_LO,     1, 16'd1,         1, 0, 0);
    add_row(ACT_COMMAND, CMD_ENABLE,      1, REPLY_OK,      1, 0, 0);
    add_row(ACT_TICK,    CMD_SPARE_MAX,   0, '0, 0, 0, 0);
    add_row(ACT_TICK,    CMD_PING,        1, REPLY_OK,      0, 1, 1);
    add_row(ACT_COMMAND, CMD_PRI_FAULTS,  0, '0, 0, 0, 0);
    add_row(ACT_COMMAND, CMD_CLEAR_CNT,   1, REPLY_OK,      1, 0, 0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      issue_request(directed_rows[i].act, directed_rows[i].code,
                    directed_rows[i].fixed, directed_rows[i].want);

    // largest base: 90 s times one runs out
    send_cmd(CMD_UNLOCK);
    send_cmd(CMD_TGT_MAIN);
    send_cmd(CMD_BASE_LO + BASE_ENTRIES - 1);
    send_cmd(CMD_MULT_LO);
    send_cmd(CMD_ENABLE);
    repeat (int'(main_base) * int'(main_mult) + 1) send_tick();
    send_cmd(CMD_PRI_FAULTS);

    // shortest interval, timeouts back to back
    send_cmd(CMD_UNLOCK);
    send_cmd(CMD_TGT_MAIN);
    send_cmd(CMD_BASE_LO);
    send_cmd(CMD_MULT_LO);
    for (round = 0; round < 20; round++) begin
      send_cmd(CMD_ENABLE);
      send_tick();
      send_tick();
      if (round % 8 == 7) send_cmd(CMD_PRI_FAULTS);
    end

    // random mixes under each idling pattern
    run_mixed(100);
    send_idle_pct = 73;
    run_mixed(100);
    send_idle_pct  = 0;
    recv_stall_pct = 73;
    run_mixed(100);
    send_idle_pct  = 25;
    recv_stall_pct = 25;
    run_mixed(100);

    // drain outstanding results
    request_ch.valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (error_cnt == 0)
      $display("tb_heartbeat_watchdog_supervisor_unit: done, clean");
    else
      $display("tb_heartbeat_watchdog_supervisor_unit: done, errors");
    $finish;
  end

endmodule
